// ===== rtl/bar_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and register indexes of the barometer compensation block.
// No dependencies; every other file uses this package by scoped names.
package bar_pkg;

   // Register indexes of the write port.
   typedef enum logic [2:0] {
      CSR_AC1_AC2  = 3'd0,
      CSR_AC3_AC4  = 3'd1,
      CSR_AC5_AC6  = 3'd2,
      CSR_B1_B2    = 3'd3,
      CSR_MC_MD    = 3'd4,
      CSR_OVERSAMP = 3'd5
   } csr_index_type;

   localparam logic [1:0] OSS_RESET = 2'd2;

   // Compensation constants.
   localparam logic signed [31:0] B6_OFFSET   = 32'sd4000;
   localparam logic signed [31:0] P_SQ_COEF   = 32'sd3038;
   localparam logic signed [31:0] P_LIN_COEF  = -32'sd7357;
   localparam logic signed [31:0] P_ROUND     = 32'sd3791;
   localparam logic [31:0]        B4_BIAS     = 32'd32768;
   localparam logic [31:0]        B7_SCALE    = 32'd50000;
   localparam logic signed [31:0] TEMP_ROUND  = 32'sd8;

   // Side data that travels with an operand pair through a divider.
   localparam int TAG_W = 58;

   // Cycles from an accepted start to the edge that takes the result.
   localparam int LATENCY = 75;

   // Calibration words as held in the register file.
   typedef struct packed {
      logic [31:0] ac1_ac2;
      logic [31:0] ac3_ac4;
      logic [31:0] ac5_ac6;
      logic [31:0] b1_b2;
      logic [31:0] mc_md;
      logic [1:0]  oss;
   } cal_type;

   // One restoring-division stage's state.
   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] num;
      logic [31:0] den;
      logic [31:0] quo;
   } div_type;

   // One quotient bit: shift in the next dividend bit and try to subtract.
   function automatic div_type div_step(input div_type s);
      div_type     r;
      logic [32:0] trial;
      logic [32:0] diff;
      trial = {s.rem, s.num[31]};
      diff  = trial - {1'b0, s.den};
      r.den = s.den;
      r.num = {s.num[30:0], 1'b0};
      if (!diff[32]) begin
         r.rem = diff[31:0];
         r.quo = {s.quo[30:0], 1'b1};
      end else begin
         r.rem = trial[31:0];
         r.quo = {s.quo[30:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ===== rtl/baro_temp_pressure_compensation.sv =====
`timescale 1ns / 1ps
// Top level of the barometer temperature and pressure compensation pipeline.
// Depends on bar_pkg, bar_csr and bar_div_pipe.
//
// Usage:
//    A reading pair (raw temperature word, raw pressure bytes) is taken at a
//    rising edge with start high and busy low. busy is high only during reset,
//    so a new pair may enter on every cycle.
//    Each pair gives one result beat: rsp_valid is high for exactly one cycle
//    with the temperature in 0.1 degC, the pressure in Pa and a divide fault
//    flag. When the fault flag is set both values are zero.
//    Throughput is one pair per cycle. A pair passes through the two 32-stage
//    divider pipelines (temperature divide and pressure divide) and eleven
//    arithmetic stages, none with more than one 32-bit multiply in series.
//    Calibration words and oversampling are written through the csr_ port,
//    one register per cycle; the user must write them only while no pair is
//    in flight, which the block itself does not enforce. Synchronous reset
//    clears every valid bit and restores the registers (calibration zero,
//    oversampling 2). The receiver cannot stall the block; results leave in
//    order on the cycle they are ready.
module baro_temp_pressure_compensation (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [15:0]        req_raw_temperature,
   input  logic [23:0]        req_raw_pressure_bytes,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_temperature_decidegrees,
   output logic signed [31:0] rsp_pressure_pascal,
   output logic               rsp_divide_fault
);

   bar_pkg::cal_type cal;

   bar_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cal              (cal)
   );

   // Calibration fields, sign or zero extended to 32 bits.
   logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic [31:0]        ac4, ac5, ac6;
   assign ac1 = {{16{cal.ac1_ac2[31]}}, cal.ac1_ac2[31:16]};
   assign ac2 = {{16{cal.ac1_ac2[15]}}, cal.ac1_ac2[15:0]};
   assign ac3 = {{16{cal.ac3_ac4[31]}}, cal.ac3_ac4[31:16]};
   assign ac4 = {16'd0, cal.ac3_ac4[15:0]};
   assign ac5 = {16'd0, cal.ac5_ac6[31:16]};
   assign ac6 = {16'd0, cal.ac5_ac6[15:0]};
   assign b1  = {{16{cal.b1_b2[31]}}, cal.b1_b2[31:16]};
   assign b2  = {{16{cal.b1_b2[15]}}, cal.b1_b2[15:0]};
   assign mc  = {{16{cal.mc_md[31]}}, cal.mc_md[31:16]};
   assign md  = {{16{cal.mc_md[15]}}, cal.mc_md[15:0]};

   assign busy = reset;

   // Valid bits of the arithmetic stages.
   logic s0_v_ff, s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff;
   logic s9_v_ff, s10_v_ff, rsp_v_ff;
   logic d1_v, d2_v;

   // Stage 0: take the beat and align the pressure word.
   logic [15:0] s0_ut_ff;
   logic [23:0] s0_up_ff, s0_up_in;
   assign s0_up_in = req_raw_pressure_bytes >> (4'd8 - {2'd0, cal.oss});

   always_ff @(posedge clock) begin
      s0_ut_ff <= req_raw_temperature;
      s0_up_ff <= s0_up_in;
   end

   // Stage 1: raw temperature product.
   logic [31:0] s1_prod_ff, s1_prod_in;
   logic [23:0] s1_up_ff;
   assign s1_prod_in = ({16'd0, s0_ut_ff} - ac6) * ac5;

   always_ff @(posedge clock) begin
      s1_prod_ff <= s1_prod_in;
      s1_up_ff   <= s0_up_ff;
   end

   // Stage 2: x1, divisor and operand magnitudes for the temperature divide.
   logic signed [31:0] s2_x1_in, s2_div_in, s2_num_in;
   logic [31:0]        s2_x1_ff, s2_ma_ff, s2_mb_ff;
   logic [23:0]        s2_up_ff;
   logic               s2_neg_ff, s2_fault_ff;
   assign s2_x1_in  = $signed(s1_prod_ff) >>> 15;
   assign s2_div_in = s2_x1_in + md;
   assign s2_num_in = mc <<< 11;

   always_ff @(posedge clock) begin
      s2_x1_ff    <= s2_x1_in;
      s2_ma_ff    <= s2_num_in[31] ? 32'd0 - s2_num_in : s2_num_in;
      s2_mb_ff    <= s2_div_in[31] ? 32'd0 - s2_div_in : s2_div_in;
      s2_neg_ff   <= s2_num_in[31] ^ s2_div_in[31];
      s2_fault_ff <= (s2_div_in == 32'sd0);
      s2_up_ff    <= s1_up_ff;
   end

   // Temperature divide.
   logic [31:0]               d1_quo;
   logic [bar_pkg::TAG_W-1:0] d1_tag;

   bar_div_pipe u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_v_ff),
      .in_num    (s2_ma_ff),
      .in_den    (s2_mb_ff),
      .in_tag    ({s2_fault_ff, s2_neg_ff, s2_x1_ff, s2_up_ff}),
      .out_valid (d1_v),
      .out_quo   (d1_quo),
      .out_tag   (d1_tag)
   );

   // Stage 3: b5, temperature and b6.
   logic signed [31:0] s3_x2_in, s3_b5_in;
   logic signed [31:0] s3_temp_ff, s3_b6_ff;
   logic [23:0]        s3_up_ff;
   logic               s3_fault_ff;
   assign s3_x2_in = d1_tag[56] ? 32'd0 - d1_quo : d1_quo;
   assign s3_b5_in = $signed(d1_tag[55:24]) + s3_x2_in;

   always_ff @(posedge clock) begin
      s3_temp_ff  <= (s3_b5_in + bar_pkg::TEMP_ROUND) >>> 4;
      s3_b6_ff    <= s3_b5_in - bar_pkg::B6_OFFSET;
      s3_fault_ff <= d1_tag[57];
      s3_up_ff    <= d1_tag[23:0];
   end

   // Stage 4: products of b6.
   logic signed [31:0] s4_sq_ff, s4_a2_ff, s4_a3_ff, s4_temp_ff;
   logic [23:0]        s4_up_ff;
   logic               s4_fault_ff;

   always_ff @(posedge clock) begin
      s4_sq_ff    <= s3_b6_ff * s3_b6_ff;
      s4_a2_ff    <= ac2 * s3_b6_ff;
      s4_a3_ff    <= ac3 * s3_b6_ff;
      s4_temp_ff  <= s3_temp_ff;
      s4_fault_ff <= s3_fault_ff;
      s4_up_ff    <= s3_up_ff;
   end

   // Stage 5: products of the squared term.
   logic signed [31:0] s5_sq_in;
   logic signed [31:0] s5_b2sq_ff, s5_b1sq_ff, s5_a2_ff, s5_a3_ff, s5_temp_ff;
   logic [23:0]        s5_up_ff;
   logic               s5_fault_ff;
   assign s5_sq_in = s4_sq_ff >>> 12;

   always_ff @(posedge clock) begin
      s5_b2sq_ff  <= b2 * s5_sq_in;
      s5_b1sq_ff  <= b1 * s5_sq_in;
      s5_a2_ff    <= s4_a2_ff;
      s5_a3_ff    <= s4_a3_ff;
      s5_temp_ff  <= s4_temp_ff;
      s5_fault_ff <= s4_fault_ff;
      s5_up_ff    <= s4_up_ff;
   end

   // Stage 6: b3 and the x3 term of b4. b3 divides by four toward zero.
   logic signed [31:0] s6_x3a_in, s6_v_in, s6_x3c_in;
   logic signed [31:0] s6_b3_ff, s6_x3c_ff, s6_temp_ff;
   logic [23:0]        s6_up_ff;
   logic               s6_fault_ff;
   assign s6_x3a_in = (s5_b2sq_ff >>> 11) + (s5_a2_ff >>> 11);
   assign s6_v_in   = (((ac1 <<< 2) + s6_x3a_in) <<< cal.oss) + 32'sd2;
   assign s6_x3c_in = ((s5_a3_ff >>> 13) + (s5_b1sq_ff >>> 16) + 32'sd2) >>> 2;

   always_ff @(posedge clock) begin
      s6_b3_ff    <= (s6_v_in + (s6_v_in[31] ? 32'sd3 : 32'sd0)) >>> 2;
      s6_x3c_ff   <= s6_x3c_in;
      s6_temp_ff  <= s5_temp_ff;
      s6_fault_ff <= s5_fault_ff;
      s6_up_ff    <= s5_up_ff;
   end

   // Stage 7: b4 and b7.
   logic [31:0]        s7_b4p_in;
   logic [31:0]        s7_b4_ff, s7_b7_ff;
   logic signed [31:0] s7_temp_ff;
   logic               s7_fault_ff;
   assign s7_b4p_in = ac4 * (s6_x3c_ff + bar_pkg::B4_BIAS);

   always_ff @(posedge clock) begin
      s7_b4_ff    <= s7_b4p_in >> 15;
      s7_b7_ff    <= ({8'd0, s6_up_ff} - s6_b3_ff) * (bar_pkg::B7_SCALE >> cal.oss);
      s7_temp_ff  <= s6_temp_ff;
      s7_fault_ff <= s6_fault_ff;
   end

   // Pressure divide: large b7 is divided first and doubled after.
   logic                      d2_large;
   logic [31:0]               d2_quo;
   logic [bar_pkg::TAG_W-1:0] d2_tag;
   assign d2_large = s7_b7_ff[31];

   bar_div_pipe u_div_pres (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s7_v_ff),
      .in_num    (d2_large ? s7_b7_ff : {s7_b7_ff[30:0], 1'b0}),
      .in_den    (s7_b4_ff),
      .in_tag    ({s7_fault_ff | (s7_b4_ff == 32'd0), d2_large, s7_temp_ff, 24'd0}),
      .out_valid (d2_v),
      .out_quo   (d2_quo),
      .out_tag   (d2_tag)
   );

   // Stage 9: p and its first products.
   logic signed [31:0] s9_p_in, s9_a_in;
   logic signed [31:0] s9_p_ff, s9_sqp_ff, s9_lin_ff, s9_temp_ff;
   logic               s9_fault_ff;
   assign s9_p_in = d2_tag[56] ? {d2_quo[30:0], 1'b0} : d2_quo;
   assign s9_a_in = s9_p_in >>> 8;

   always_ff @(posedge clock) begin
      s9_p_ff     <= s9_p_in;
      s9_sqp_ff   <= s9_a_in * s9_a_in;
      s9_lin_ff   <= bar_pkg::P_LIN_COEF * s9_p_in;
      s9_temp_ff  <= $signed(d2_tag[55:24]);
      s9_fault_ff <= d2_tag[57];
   end

   // Stage 10: scaled square term.
   logic signed [31:0] s10_p_ff, s10_x1p_ff, s10_x2_ff, s10_temp_ff;
   logic               s10_fault_ff;

   always_ff @(posedge clock) begin
      s10_p_ff     <= s9_p_ff;
      s10_x1p_ff   <= s9_sqp_ff * bar_pkg::P_SQ_COEF;
      s10_x2_ff    <= s9_lin_ff >>> 16;
      s10_temp_ff  <= s9_temp_ff;
      s10_fault_ff <= s9_fault_ff;
   end

   // Stage 11: final pressure and the result beat.
   logic signed [31:0] rsp_pres_in;
   logic signed [31:0] rsp_temp_ff, rsp_pres_ff;
   logic               rsp_fault_ff;
   assign rsp_pres_in = s10_p_ff +
                        (((s10_x1p_ff >>> 16) + s10_x2_ff + bar_pkg::P_ROUND) >>> 4);

   always_ff @(posedge clock) begin
      rsp_temp_ff  <= s10_fault_ff ? 32'sd0 : s10_temp_ff;
      rsp_pres_ff  <= s10_fault_ff ? 32'sd0 : rsp_pres_in;
      rsp_fault_ff <= s10_fault_ff;
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         s6_v_ff  <= 1'b0;
         s7_v_ff  <= 1'b0;
         s9_v_ff  <= 1'b0;
         s10_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         s0_v_ff  <= start && !busy;
         s1_v_ff  <= s0_v_ff;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= d1_v;
         s4_v_ff  <= s3_v_ff;
         s5_v_ff  <= s4_v_ff;
         s6_v_ff  <= s5_v_ff;
         s7_v_ff  <= s6_v_ff;
         s9_v_ff  <= d2_v;
         s10_v_ff <= s9_v_ff;
         rsp_v_ff <= s10_v_ff;
      end
   end

   assign rsp_valid                   = rsp_v_ff;
   assign rsp_temperature_decidegrees = rsp_temp_ff;
   assign rsp_pressure_pascal         = rsp_pres_ff;
   assign rsp_divide_fault            = rsp_fault_ff;

endmodule

// ===== rtl/bar_csr.sv =====
`timescale 1ns / 1ps
// Calibration and oversampling register file of the barometer compensation block.
// Depends on bar_pkg.
module bar_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_write_data,
   output bar_pkg::cal_type    cal
);

   bar_pkg::cal_type cal_ff;
   bar_pkg::cal_type cal_in;

   // Decode the write; indexes past the list leave everything alone.
   always_comb begin
      cal_in = cal_ff;
      if (csr_write_enable) begin
         case (csr_index)
            bar_pkg::CSR_AC1_AC2:  cal_in.ac1_ac2 = csr_write_data;
            bar_pkg::CSR_AC3_AC4:  cal_in.ac3_ac4 = csr_write_data;
            bar_pkg::CSR_AC5_AC6:  cal_in.ac5_ac6 = csr_write_data;
            bar_pkg::CSR_B1_B2:    cal_in.b1_b2   = csr_write_data;
            bar_pkg::CSR_MC_MD:    cal_in.mc_md   = csr_write_data;
            bar_pkg::CSR_OVERSAMP: cal_in.oss     = csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.ac1_ac2 <= '0;
         cal_ff.ac3_ac4 <= '0;
         cal_ff.ac5_ac6 <= '0;
         cal_ff.b1_b2   <= '0;
         cal_ff.mc_md   <= '0;
         cal_ff.oss     <= bar_pkg::OSS_RESET;
      end else begin
         cal_ff <= cal_in;
      end
   end

   assign cal = cal_ff;

endmodule

// ===== rtl/bar_div_pipe.sv =====
`timescale 1ns / 1ps
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// Depends on bar_pkg; side data rides along in a tag.
module bar_div_pipe (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [31:0]               in_num,
   input  logic [31:0]               in_den,
   input  logic [bar_pkg::TAG_W-1:0] in_tag,
   output logic                      out_valid,
   output logic [31:0]               out_quo,
   output logic [bar_pkg::TAG_W-1:0] out_tag
);

   bar_pkg::div_type                 stage_ff [0:31];
   bar_pkg::div_type                 stage_in [0:31];
   logic [bar_pkg::TAG_W-1:0]        tag_ff   [0:31];
   logic [31:0]                      valid_ff;
   bar_pkg::div_type                 first;

   // Each stage works on the one before it; stage zero on the operands.
   always_comb begin
      first.rem = '0;
      first.num = in_num;
      first.den = in_den;
      first.quo = '0;
      stage_in[0] = bar_pkg::div_step(first);
      for (int k = 1; k < 32; k++) begin
         stage_in[k] = bar_pkg::div_step(stage_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[30:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      stage_ff[0] <= stage_in[0];
      tag_ff[0]   <= in_tag;
      for (int k = 1; k < 32; k++) begin
         stage_ff[k] <= stage_in[k];
         tag_ff[k]   <= tag_ff[k-1];
      end
   end

   assign out_valid = valid_ff[31];
   assign out_quo   = stage_ff[31].quo;
   assign out_tag   = tag_ff[31];

endmodule

// ===== rtl/bar_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the barometer compensation block, bound to its top level.
// Depends on bar_pkg.
module bar_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_temperature_decidegrees,
   input logic signed [31:0] rsp_pressure_pascal,
   input logic               rsp_divide_fault
);

   // Reset empties the pipeline.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   // A faulted result carries zero values.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_fault |->
         rsp_temperature_decidegrees == 32'sd0 && rsp_pressure_pascal == 32'sd0)
      else $error("faulted result with nonzero values");

   // Every result beat goes back to an accepted start a fixed latency earlier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, bar_pkg::LATENCY))
      else $error("result beat without a matching start");

   // Busy only reflects reset.
   assert property (@(posedge clock) !reset |-> !busy)
      else $error("busy outside reset");

endmodule

bind baro_temp_pressure_compensation bar_checker u_bar_checker (
   .clock                       (clock),
   .reset                       (reset),
   .start                       (start),
   .busy                        (busy),
   .rsp_valid                   (rsp_valid),
   .rsp_temperature_decidegrees (rsp_temperature_decidegrees),
   .rsp_pressure_pascal         (rsp_pressure_pascal),
   .rsp_divide_fault            (rsp_divide_fault)
);

// ===== test/baro_temp_pressure_compensation_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the barometer compensation pipeline: a queue-fed driver,
// a strobe monitor and an in-bench compensation predictor. Depends on bar_pkg and the RTL.
module baro_temp_pressure_compensation_tb;

   typedef struct packed {
      logic [15:0] raw_t;
      logic [23:0] raw_p;
   } reading_type;

   typedef struct packed {
      logic signed [31:0] temp_dc;
      logic signed [31:0] pres_pa;
      logic               fault;
   } comp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [15:0]        req_raw_temperature = '0;
   logic [23:0]        req_raw_pressure_bytes = '0;
   logic               csr_write_enable = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_write_data = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_temperature_decidegrees;
   logic signed [31:0] rsp_pressure_pascal;
   logic               rsp_divide_fault;

   // Predictor copy of the calibration registers.
   logic [31:0] cal_words [0:4];
   logic [1:0]  cal_oss;

   reading_type pending_readings[$];
   comp_type    expected_results[$];
   int          mismatch_count = 0;
   int          result_count = 0;
   int          fault_count = 0;
   bit          idle_enable = 1'b1;
   int          gap_left = 0;

   baro_temp_pressure_compensation u_top (.*);

   always #5 clock = ~clock;

   // Signed division truncating toward zero; divisor nonzero.
   function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q  = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic logic [31:0] sext16(input logic [15:0] h);
      return {{16{h[15]}}, h};
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
      return $unsigned($signed(x) >>> n);
   endfunction

   // Integer compensation of one reading pair, all in 32-bit wrapping arithmetic.
   function automatic comp_type compensate(input reading_type rd);
      comp_type    r;
      logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, dv, temp;
      r  = '{temp_dc: '0, pres_pa: '0, fault: 1'b1};
      ut = {16'd0, rd.raw_t};
      up = {8'd0, rd.raw_p} >> (8 - cal_oss);
      ac1 = sext16(cal_words[0][31:16]); ac2 = sext16(cal_words[0][15:0]);
      ac3 = sext16(cal_words[1][31:16]); ac4 = {16'd0, cal_words[1][15:0]};
      ac5 = {16'd0, cal_words[2][31:16]}; ac6 = {16'd0, cal_words[2][15:0]};
      b1 = sext16(cal_words[3][31:16]); b2 = sext16(cal_words[3][15:0]);
      mc = sext16(cal_words[4][31:16]); md = sext16(cal_words[4][15:0]);
      x1 = asr32((ut - ac6) * ac5, 15);
      dv = x1 + md;
      if (dv == 0) return r;
      x2 = div_trunc(mc * 32'd2048, dv);
      b5 = x1 + x2;
      temp = asr32(b5 + 32'd8, 4);
      b6 = b5 - 32'd4000;
      sq = asr32(b6 * b6, 12);
      x1 = asr32(b2 * sq, 11);
      x2 = asr32(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = div_trunc(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 32'd4);
      x1 = asr32(ac3 * b6, 13);
      x2 = asr32(b1 * sq, 16);
      x3 = asr32(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      if (b4 == 0) return r;
      b7 = (up - b3) * (32'd50000 >> cal_oss);
      if (!b7[31]) p = (b7 * 32'd2) / b4;
      else         p = (b7 / b4) * 32'd2;
      x1 = asr32(p, 8) * asr32(p, 8);
      x1 = asr32(x1 * 32'd3038, 16);
      x2 = asr32(-32'd7357 * p, 16);
      r.temp_dc = temp;
      r.pres_pa = p + asr32(x1 + x2 + 32'd3791, 4);
      r.fault   = 1'b0;
      return r;
   endfunction

   // Driver: one beat per accepted edge, with random idle bursts.
   always @(posedge clock) begin
      reading_type rd;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_results.push_back(compensate({req_raw_temperature,
                                                   req_raw_pressure_bytes}));
         end
         if (start && busy) begin
            // Hold the current beat until it is taken.
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 15) == 0) begin
            gap_left <= $urandom_range(0, 16);
            start <= 1'b0;
         end else if (pending_readings.size() > 0) begin
            rd = pending_readings.pop_front();
            req_raw_temperature    <= rd.raw_t;
            req_raw_pressure_bytes <= rd.raw_p;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: each strobed result against the oldest expectation.
   always @(posedge clock) begin
      comp_type want;
      if (!reset && rsp_valid) begin
         result_count <= result_count + 1;
         if (expected_results.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) $display("unexpected result beat at %0t", $time);
         end else begin
            want = expected_results.pop_front();
            if (want.fault) fault_count <= fault_count + 1;
            if (rsp_temperature_decidegrees !== want.temp_dc ||
                rsp_pressure_pascal !== want.pres_pa || rsp_divide_fault !== want.fault) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("result mismatch: expected t=%0d p=%0d f=%0b, got t=%0d p=%0d f=%0b",
                           want.temp_dc, want.pres_pa, want.fault,
                           rsp_temperature_decidegrees, rsp_pressure_pascal,
                           rsp_divide_fault);
            end
         end
      end
   end

   task automatic write_csr(input bar_pkg::csr_index_type idx, input logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == bar_pkg::CSR_OVERSAMP) cal_oss = data[1:0];
      else                              cal_words[idx] = data;
   endtask

   // Waits until every queued beat has been sent and answered.
   task automatic drain_pipeline();
      while (pending_readings.size() > 0 || start || expected_results.size() > 0)
         @(posedge clock);
      repeat (bar_pkg::LATENCY + 5) @(posedge clock);
   endtask

   // Typical sensor calibration or fully random words, then the oversampling setting.
   task automatic load_calibration(input bit typical, input logic [1:0] oss);
      if (typical) begin
         write_csr(bar_pkg::CSR_AC1_AC2, {16'd408, -16'sd72});
         write_csr(bar_pkg::CSR_AC3_AC4, {-16'sd14383, 16'd32741});
         write_csr(bar_pkg::CSR_AC5_AC6, {16'd32757, 16'd23153});
         write_csr(bar_pkg::CSR_B1_B2, {16'd6190, 16'd4});
         write_csr(bar_pkg::CSR_MC_MD, {-16'sd8711, 16'd2868});
      end else begin
         write_csr(bar_pkg::CSR_AC1_AC2, $urandom());
         write_csr(bar_pkg::CSR_AC3_AC4, $urandom());
         write_csr(bar_pkg::CSR_AC5_AC6, $urandom());
         write_csr(bar_pkg::CSR_B1_B2, $urandom());
         write_csr(bar_pkg::CSR_MC_MD, $urandom());
      end
      write_csr(bar_pkg::CSR_OVERSAMP, {30'd0, oss});
   endtask

   function automatic reading_type random_reading();
      reading_type rd;
      case ($urandom_range(0, 3))
         0:       rd = {16'($urandom()), 24'($urandom())};
         1:       rd = {16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0000), 24'($urandom())};
         default: rd = {16'($urandom_range(20000, 35000)), 24'($urandom_range(0, 24'hFFFFFF))};
      endcase
      return rd;
   endfunction

   initial begin
      int phase;
      for (int i = 0; i < 5; i++) cal_words[i] = '0;
      cal_oss = bar_pkg::OSS_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset calibration: ac5 is zero, so md of zero faults the temperature divide.
      pending_readings.push_back({16'd27898, 24'h5D23FF});
      pending_readings.push_back({16'hFFFF, 24'hFFFFFF});
      drain_pipeline();

      // Directed part on the typical calibration over every oversampling setting.
      for (int o = 0; o < 4; o++) begin
         load_calibration(1'b1, 2'(o));
         pending_readings.push_back({16'd27898, 24'h5D23FF});
         pending_readings.push_back({16'h0000, 24'h000000});
         pending_readings.push_back({16'hFFFF, 24'hFFFFFF});
         pending_readings.push_back({16'h5555, 24'hAAAAAA});
         pending_readings.push_back({16'hAAAA, 24'h555555});
         drain_pipeline();
      end

      // Zero pressure divisor: ac4 zero forces b4 to zero.
      write_csr(bar_pkg::CSR_AC3_AC4, {-16'sd14383, 16'd0});
      pending_readings.push_back({16'd27898, 24'h5D23FF});
      drain_pipeline();
      // Zero temperature divisor with nonzero ac5: ut equal to ac6, md zero.
      write_csr(bar_pkg::CSR_MC_MD, {-16'sd8711, 16'd0});
      pending_readings.push_back({16'd23153, 24'h5D23FF});
      pending_readings.push_back({16'd23154, 24'h5D23FF});
      drain_pipeline();
      // Extreme calibration words, including a write to an index beyond the list.
      write_csr(bar_pkg::CSR_AC1_AC2, 32'h8000_7FFF);
      write_csr(bar_pkg::CSR_AC3_AC4, 32'h7FFF_FFFF);
      write_csr(bar_pkg::CSR_AC5_AC6, 32'hFFFF_0000);
      write_csr(bar_pkg::CSR_B1_B2, 32'h8000_8000);
      write_csr(bar_pkg::CSR_MC_MD, 32'h7FFF_FFFF);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= 3'd7;
      csr_write_data   <= 32'hFFFF_FFFF;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pending_readings.push_back({16'hFFFF, 24'hFFFFFF});
      pending_readings.push_back({16'h0000, 24'h000000});
      drain_pipeline();

      // Random phases: mostly the typical calibration, some fully random.
      for (phase = 0; phase < 16; phase++) begin
         load_calibration($urandom_range(0, 2) != 0, 2'($urandom_range(0, 3)));
         if (phase == 15) idle_enable = 1'b0;
         for (int k = 0; k < 100; k++) pending_readings.push_back(random_reading());
         drain_pipeline();
      end

      $display("Covered %0d result beats, %0d with a divide fault, over %0d phases.",
               result_count, fault_count, phase + 8);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("baro_temp_pressure_compensation: match");
      else
         $display("baro_temp_pressure_compensation: mismatch");
      $finish;
   end

   initial begin
      #5ms;
      $display("baro_temp_pressure_compensation: mismatch");
      $finish;
   end

endmodule
